// ===== src/cpr_pkg.sv =====
`default_nettype none
package cpr_pkg;

  localparam int ENTRIES          = 16;
  localparam int PAGE_NUMBER_BITS = 20;
  localparam int SLOT_BITS        = 4;
  localparam int STATUS_BITS      = 3;
  localparam int LIMIT_BITS       = 5;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 32;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_PLACED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_REPLACED = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_RESIDENT = 3'd4;

  localparam logic CFG_POLICY   = 1'b0;
  localparam logic CFG_WS_LIMIT = 1'b1;

  localparam logic POLICY_CLOCK  = 1'b0;
  localparam logic POLICY_MCLOCK = 1'b1;

  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_FAULT  = 1'b1;

  typedef struct packed {
    logic                        func;
    logic [PAGE_NUMBER_BITS-1:0] page_number;
    logic                        is_write;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic [SLOT_BITS-1:0]        slot;
    logic [PAGE_NUMBER_BITS-1:0] victim_page;
    logic                        victim_dirty;
  } out_word_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_LK_RD,
    DP_LK_NEXT,
    DP_HIT_ACC,
    DP_MISS_ACC,
    DP_RES_FAULT,
    DP_PLACE,
    DP_REPL_INIT,
    DP_PC_STEP,
    DP_V_RD,
    DP_PC_FIN,
    DP_MC_STEP,
    DP_MC_NEXTPASS,
    DP_MC_FALLBACK,
    DP_MC_CAP,
    DP_CP_RD,
    DP_CP_WR,
    DP_MC_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_MISS,
    S_PC_SCAN,
    S_PC_FIN,
    S_MC_SCAN,
    S_MC_VRD,
    S_MC_CAP,
    S_CP_RD,
    S_CP_WR,
    S_MC_FIN
  } ctl_state_t;

  typedef struct packed {
    logic n_zero;
    logic func;
    logic lk_match;
    logic lk_last;
    logic n_lt_lim;
    logic used_cur;
    logic mc_match;
    logic k_last;
    logic pass_last;
    logic cp_more;
    logic cp_more2;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/clock_page_replacement.sv =====
`default_nettype none
// Lookup: each resident entry is read and then compared in turn; an access or resident fault
//   strobes its result at the matching slot, a miss or placement once every entry is compared.
// A plain clock replacement clears and skips each used page from the hand; modified clock scans
//   in passes from the hand, then shifts every entry behind the victim down one slot.
// Flow: one word at a time; busy drops as the result strobes.
// Reset: synchronous rst_n empties the working set, clears marks and hand, policy 0, limit 16.
module clock_page_replacement #(
  parameter int ENTRIES = cpr_pkg::ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire cpr_pkg::in_word_t                  in_word,
  output logic                                    out_valid,
  output cpr_pkg::out_word_t                      out_word,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [cpr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [cpr_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [cpr_pkg::CFG_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);

  logic                             policy_r;
  logic [cpr_pkg::LIMIT_BITS-1:0]   ws_limit_r;
  logic                             cfg_wr;
  logic                             cfg_sel;
  cpr_pkg::dp_op_t                  op;
  cpr_pkg::dp_stat_t                stat;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= cpr_pkg::POLICY_CLOCK;
      ws_limit_r <= cpr_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        cpr_pkg::CFG_POLICY: begin
          policy_r <= pwdata[0];
        end
        cpr_pkg::CFG_WS_LIMIT: begin
          ws_limit_r <= pwdata[cpr_pkg::LIMIT_BITS-1:0];
        end
        default: begin
          policy_r <= policy_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      cpr_pkg::CFG_POLICY: begin
        prdata = cpr_pkg::CFG_DATA_BITS'(policy_r);
      end
      default: begin
        prdata = cpr_pkg::CFG_DATA_BITS'(ws_limit_r);
      end
    endcase
  end

  cpr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .policy (policy_r),
    .stat   (stat),
    .op     (op),
    .busy   (busy)
  );

  cpr_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ws_limit  (ws_limit_r),
    .op        (op),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== src/cpr_datapath.sv =====
`default_nettype none
module cpr_datapath #(
  parameter int ENTRIES = cpr_pkg::ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cpr_pkg::in_word_t               in_word,
  input  wire logic [cpr_pkg::LIMIT_BITS-1:0]  ws_limit,
  input  wire cpr_pkg::dp_op_t                 op,
  output cpr_pkg::dp_stat_t                    stat,
  output logic                                 out_valid,
  output cpr_pkg::out_word_t                   out_word
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > cpr_pkg::LIMIT_BITS) ? CW : cpr_pkg::LIMIT_BITS;
  localparam int PB = cpr_pkg::PAGE_NUMBER_BITS;

  cpr_pkg::in_word_t  item_r;
  cpr_pkg::out_word_t out_word_r;
  logic               out_valid_r;

  logic [PB-1:0]      tag_mem [ENTRIES];
  logic [PB-1:0]      mem_q_r;
  logic [ENTRIES-1:0] used_r;
  logic [ENTRIES-1:0] dirty_r;
  logic [CW-1:0]      n_r;
  logic [IW-1:0]      hand_r;
  logic               hv_r;
  logic [IW-1:0]      ptr_r;
  logic [IW-1:0]      start_r;
  logic [IW-1:0]      k_r;
  logic [1:0]         pass_r;
  logic [IW-1:0]      vic_r;
  logic [PB-1:0]      vpage_r;
  logic               vdirty_r;

  logic [CW:0]   ptr_w;
  logic [CW:0]   n_w;
  logic [CW:0]   ptr_inc;
  logic [IW-1:0] ptr_wrap;
  logic [IW-1:0] nm1;
  logic [LW-1:0] lim;
  logic [IW-1:0] start_sel;
  logic [IW-1:0] rd_idx;
  logic          used_cur;
  logic          dirty_cur;
  logic          mc_match;
  logic          mc_clr;
  logic          emit;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [PB-1:0] mem_wd;

  function automatic logic [cpr_pkg::SLOT_BITS-1:0] to_slot(input logic [IW-1:0] x);
    logic [IW+cpr_pkg::SLOT_BITS-1:0] e;
    e = (IW + cpr_pkg::SLOT_BITS)'(x);
    return e[cpr_pkg::SLOT_BITS-1:0];
  endfunction

  always_comb begin
    ptr_w    = (CW + 1)'(ptr_r);
    n_w      = (CW + 1)'(n_r);
    ptr_inc  = ptr_w + 1'b1;
    ptr_wrap = (ptr_inc == n_w) ? '0 : IW'(ptr_inc);
    nm1      = IW'(n_w - 1'b1);
    if (ws_limit == '0) begin
      lim = LW'(1);
    end else if (LW'(ws_limit) > LW'(ENTRIES)) begin
      lim = LW'(ENTRIES);
    end else begin
      lim = LW'(ws_limit);
    end
    start_sel = (hv_r && ((CW + 1)'(hand_r) < n_w)) ? hand_r : '0;
    rd_idx    = (op == cpr_pkg::DP_CP_RD || op == cpr_pkg::DP_CP_WR) ? IW'(ptr_inc) : ptr_r;
    used_cur  = used_r[ptr_r];
    dirty_cur = dirty_r[ptr_r];
    case (pass_r)
      2'd0: begin
        mc_match = !used_cur && !dirty_cur;
        mc_clr   = used_cur && !dirty_cur;
      end
      2'd1: begin
        mc_match = !used_cur && dirty_cur;
        mc_clr   = used_cur && dirty_cur;
      end
      2'd2: begin
        mc_match = !used_cur && !dirty_cur;
        mc_clr   = 1'b0;
      end
      default: begin
        mc_match = !used_cur;
        mc_clr   = 1'b0;
      end
    endcase
    emit = (op == cpr_pkg::DP_HIT_ACC) || (op == cpr_pkg::DP_MISS_ACC) ||
           (op == cpr_pkg::DP_RES_FAULT) || (op == cpr_pkg::DP_PLACE) ||
           (op == cpr_pkg::DP_PC_FIN) || (op == cpr_pkg::DP_MC_FIN);
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = item_r.page_number;
    case (op)
      cpr_pkg::DP_PLACE: begin
        mem_we = 1'b1;
        mem_wa = IW'(n_r);
      end
      cpr_pkg::DP_PC_FIN: begin
        mem_we = 1'b1;
      end
      cpr_pkg::DP_CP_WR: begin
        mem_we = 1'b1;
        mem_wd = mem_q_r;
      end
      cpr_pkg::DP_MC_FIN: begin
        mem_we = 1'b1;
        mem_wa = nm1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    stat.n_zero    = (n_r == '0);
    stat.func      = item_r.func;
    stat.lk_match  = (mem_q_r == item_r.page_number);
    stat.lk_last   = (ptr_inc == n_w);
    stat.n_lt_lim  = (LW'(n_r) < lim);
    stat.used_cur  = used_cur;
    stat.mc_match  = mc_match;
    stat.k_last    = (((CW + 1)'(k_r) + 1'b1) == n_w);
    stat.pass_last = (pass_r == 2'd3);
    stat.cp_more   = (ptr_inc < n_w);
    stat.cp_more2  = ((ptr_w + 2'd2) < n_w);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= tag_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    case (op)
      cpr_pkg::DP_LOAD: begin
        item_r <= in_word;
      end
      cpr_pkg::DP_HIT_ACC: begin
        out_word_r <= '{cpr_pkg::ST_HIT, to_slot(ptr_r), '0, 1'b0};
      end
      cpr_pkg::DP_MISS_ACC: begin
        out_word_r <= '{cpr_pkg::ST_MISS, '0, '0, 1'b0};
      end
      cpr_pkg::DP_RES_FAULT: begin
        out_word_r <= '{cpr_pkg::ST_RESIDENT, to_slot(ptr_r), '0, 1'b0};
      end
      cpr_pkg::DP_PLACE: begin
        out_word_r <= '{cpr_pkg::ST_PLACED, to_slot(IW'(n_r)), '0, 1'b0};
      end
      cpr_pkg::DP_PC_FIN: begin
        out_word_r <= '{cpr_pkg::ST_REPLACED, to_slot(ptr_r), mem_q_r, dirty_cur};
      end
      cpr_pkg::DP_MC_CAP: begin
        vpage_r  <= mem_q_r;
        vdirty_r <= dirty_cur;
      end
      cpr_pkg::DP_MC_FIN: begin
        out_word_r <= '{cpr_pkg::ST_REPLACED, to_slot(nm1), vpage_r, vdirty_r};
      end
      default: begin
        out_word_r <= out_word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      dirty_r     <= '0;
      n_r         <= '0;
      hand_r      <= '0;
      hv_r        <= 1'b0;
      ptr_r       <= '0;
      start_r     <= '0;
      k_r         <= '0;
      pass_r      <= '0;
      vic_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      case (op)
        cpr_pkg::DP_LOAD: begin
          ptr_r <= '0;
        end
        cpr_pkg::DP_LK_NEXT: begin
          ptr_r <= IW'(ptr_inc);
        end
        cpr_pkg::DP_HIT_ACC: begin
          used_r[ptr_r] <= 1'b1;
          if (item_r.is_write) begin
            dirty_r[ptr_r] <= 1'b1;
          end
        end
        cpr_pkg::DP_PLACE: begin
          used_r[IW'(n_r)]  <= 1'b0;
          dirty_r[IW'(n_r)] <= 1'b0;
          n_r               <= CW'(n_w + 1'b1);
          hv_r              <= (LW'(n_w + 1'b1) == lim);
          hand_r            <= '0;
        end
        cpr_pkg::DP_REPL_INIT: begin
          ptr_r   <= start_sel;
          start_r <= start_sel;
          k_r     <= '0;
          pass_r  <= '0;
        end
        cpr_pkg::DP_PC_STEP: begin
          used_r[ptr_r] <= 1'b0;
          ptr_r         <= ptr_wrap;
        end
        cpr_pkg::DP_PC_FIN: begin
          used_r[ptr_r]  <= 1'b0;
          dirty_r[ptr_r] <= 1'b0;
          hand_r         <= ptr_wrap;
          hv_r           <= 1'b1;
        end
        cpr_pkg::DP_MC_STEP: begin
          if (mc_clr) begin
            used_r[ptr_r] <= 1'b0;
          end
          ptr_r <= ptr_wrap;
          k_r   <= k_r + 1'b1;
        end
        cpr_pkg::DP_MC_NEXTPASS: begin
          if (mc_clr) begin
            used_r[ptr_r] <= 1'b0;
          end
          ptr_r  <= start_r;
          k_r    <= '0;
          pass_r <= pass_r + 1'b1;
        end
        cpr_pkg::DP_MC_FALLBACK: begin
          ptr_r <= start_r;
        end
        cpr_pkg::DP_MC_CAP: begin
          vic_r <= ptr_r;
        end
        cpr_pkg::DP_CP_WR: begin
          used_r[ptr_r]  <= used_r[IW'(ptr_inc)];
          dirty_r[ptr_r] <= dirty_r[IW'(ptr_inc)];
          ptr_r          <= IW'(ptr_inc);
        end
        cpr_pkg::DP_MC_FIN: begin
          used_r[nm1]  <= 1'b0;
          dirty_r[nm1] <= 1'b0;
          hand_r       <= (((CW + 1)'(vic_r) + 1'b1) < n_w) ? vic_r : '0;
          hv_r         <= 1'b1;
        end
        default: begin
          ptr_r <= ptr_r;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r <= CW'(ENTRIES)))
    else $error("resident count above capacity");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cpr_pkg::DP_PLACE) |=> (n_r == CW'($past(n_r) + 1'b1)))
    else $error("placement did not grow the set");

  a_repl_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cpr_pkg::DP_REPL_INIT) |=> $stable(n_r))
    else $error("replacement changed the resident count");

  a_repl_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == cpr_pkg::ST_REPLACED) |-> hv_r)
    else $error("hand not valid after replacement");

  a_compact_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cpr_pkg::DP_CP_WR) |-> (ptr_inc < n_w))
    else $error("compaction past the resident count");
`endif

endmodule
`default_nettype wire

// ===== src/cpr_ctrl.sv =====
`default_nettype none
module cpr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              policy,
  input  wire cpr_pkg::dp_stat_t stat,
  output cpr_pkg::dp_op_t        op,
  output logic                   busy
);

  cpr_pkg::ctl_state_t state_r;
  cpr_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = cpr_pkg::DP_NOP;
    busy      = (state_r != cpr_pkg::S_IDLE);
    case (state_r)
      cpr_pkg::S_IDLE: begin
        if (start) begin
          op        = cpr_pkg::DP_LOAD;
          state_nxt = stat.n_zero ? cpr_pkg::S_MISS : cpr_pkg::S_LK_RD;
        end
      end
      cpr_pkg::S_LK_RD: begin
        op        = cpr_pkg::DP_LK_RD;
        state_nxt = cpr_pkg::S_LK_CMP;
      end
      cpr_pkg::S_LK_CMP: begin
        if (stat.lk_match) begin
          op        = (stat.func == cpr_pkg::FUNC_FAULT) ? cpr_pkg::DP_RES_FAULT
                                                         : cpr_pkg::DP_HIT_ACC;
          state_nxt = cpr_pkg::S_IDLE;
        end else if (stat.lk_last) begin
          state_nxt = cpr_pkg::S_MISS;
        end else begin
          op        = cpr_pkg::DP_LK_NEXT;
          state_nxt = cpr_pkg::S_LK_RD;
        end
      end
      cpr_pkg::S_MISS: begin
        if (stat.func == cpr_pkg::FUNC_ACCESS) begin
          op        = cpr_pkg::DP_MISS_ACC;
          state_nxt = cpr_pkg::S_IDLE;
        end else if (stat.n_lt_lim) begin
          op        = cpr_pkg::DP_PLACE;
          state_nxt = cpr_pkg::S_IDLE;
        end else begin
          op        = cpr_pkg::DP_REPL_INIT;
          state_nxt = (policy == cpr_pkg::POLICY_MCLOCK) ? cpr_pkg::S_MC_SCAN
                                                         : cpr_pkg::S_PC_SCAN;
        end
      end
      cpr_pkg::S_PC_SCAN: begin
        if (stat.used_cur) begin
          op = cpr_pkg::DP_PC_STEP;
        end else begin
          op        = cpr_pkg::DP_V_RD;
          state_nxt = cpr_pkg::S_PC_FIN;
        end
      end
      cpr_pkg::S_PC_FIN: begin
        op        = cpr_pkg::DP_PC_FIN;
        state_nxt = cpr_pkg::S_IDLE;
      end
      cpr_pkg::S_MC_SCAN: begin
        if (stat.mc_match) begin
          op        = cpr_pkg::DP_V_RD;
          state_nxt = cpr_pkg::S_MC_CAP;
        end else if (!stat.k_last) begin
          op = cpr_pkg::DP_MC_STEP;
        end else if (!stat.pass_last) begin
          op = cpr_pkg::DP_MC_NEXTPASS;
        end else begin
          op        = cpr_pkg::DP_MC_FALLBACK;
          state_nxt = cpr_pkg::S_MC_VRD;
        end
      end
      cpr_pkg::S_MC_VRD: begin
        op        = cpr_pkg::DP_V_RD;
        state_nxt = cpr_pkg::S_MC_CAP;
      end
      cpr_pkg::S_MC_CAP: begin
        op        = cpr_pkg::DP_MC_CAP;
        state_nxt = stat.cp_more ? cpr_pkg::S_CP_RD : cpr_pkg::S_MC_FIN;
      end
      cpr_pkg::S_CP_RD: begin
        op        = cpr_pkg::DP_CP_RD;
        state_nxt = cpr_pkg::S_CP_WR;
      end
      cpr_pkg::S_CP_WR: begin
        op        = cpr_pkg::DP_CP_WR;
        state_nxt = stat.cp_more2 ? cpr_pkg::S_CP_RD : cpr_pkg::S_MC_FIN;
      end
      cpr_pkg::S_MC_FIN: begin
        op        = cpr_pkg::DP_MC_FIN;
        state_nxt = cpr_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cpr_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cpr_pkg::DP_LOAD) |-> (state_r == cpr_pkg::S_IDLE))
    else $error("word loaded while busy");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == cpr_pkg::DP_MC_FIN || op == cpr_pkg::DP_PC_FIN) |=> !busy)
    else $error("replacement did not return to idle");
`endif

endmodule
`default_nettype wire
